// ----- src/erpp_pkg.sv -----
package erpp_pkg;

	localparam logic [7:0]  SYNC_BYTE = 8'hFF;
	localparam logic [7:0]  LEN_MARK  = 8'h0C;
	localparam logic [3:0]  BODY_OFF  = 4'd3;
	localparam logic [3:0]  LAST_OFF  = 4'd14;

	localparam logic [15:0] CPR_RESET = 16'd3126;
	localparam logic [7:0]  ID_RESET  = 8'd1;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CPR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ID  = 8'd1;

	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 4;

	localparam int TICKS_W = 33;

	typedef enum logic [2:0] {
		ST_HUNT = 3'd0,
		ST_FF1  = 3'd1,
		ST_FF2  = 3'd2,
		ST_ID   = 3'd3,
		ST_BODY = 3'd4
	} phase_t;

	typedef struct packed {
		logic        pos_sign;
		logic [15:0] rounds;
		logic [15:0] position;
	} wheel_t;

	typedef struct packed {
		wheel_t left;
		wheel_t right;
	} pkt_t;

	typedef struct packed {
		logic signed [TICKS_W-1:0] left;
		logic signed [TICKS_W-1:0] right;
	} ticks_t;

	// queue status, seen by the side that fills it (full) and the side that drains it (empty)
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ----- src/encoder_reply_packet_parser.sv -----
// Path: a packet goes from the packet queue through the multiply stage and the
// add/negate stage into the result queue, and waits while that queue lacks room.
// Throughput: one byte per cycle while full is low; full rises only when the
// output side has stalled and the packet queue holds MID_DEPTH packets.
// Reset: arst_n clears the hunt state and all queues; counts_per_round to 3126,
// device_id to 1.
module encoder_reply_packet_parser import erpp_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  rx_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [TICKS_W-1:0]   left_ticks,
	output logic signed [TICKS_W-1:0]   right_ticks,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data
);

	logic [15:0]                  cpr_q;
	logic [7:0]                   dev_id_q;
	logic                         accept;
	logic                         pkt_push, pkt_pop;
	pkt_t                         pkt_in, pkt_out;
	q_stat_t                      mid_stat;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_cnt;
	ticks_t                       ticks;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q    <= CPR_RESET;
			dev_id_q <= ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CPR: cpr_q    <= cfg_data;
				REG_ID:  dev_id_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign full   = mid_stat.full;
	assign accept = push && !full;

	erpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.device_id (dev_id_q),
		.pkt_push  (pkt_push),
		.pkt       (pkt_in)
	);

	erpp_fifo #(
		.WIDTH ($bits(pkt_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pkt_push),
		.din    (pkt_in),
		.pop    (pkt_pop),
		.dout   (pkt_out),
		.stat   (mid_stat),
		.count  (mid_cnt)
	);

	erpp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.counts_per_round (cpr_q),
		.pkt              (pkt_out),
		.mid_stat         (mid_stat),
		.pkt_pop          (pkt_pop),
		.pop              (pop),
		.empty            (empty),
		.ticks            (ticks)
	);

	assign left_ticks  = ticks.left;
	assign right_ticks = ticks.right;

	a_mid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_push && !pkt_pop && !mid_stat.full |=> mid_cnt != '0)
		else $error("packet queue lost a request");

endmodule

// ----- src/erpp_fifo.sv -----
module erpp_fifo import erpp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = MID_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output q_stat_t                    stat,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH-1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == FULL_CNT);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = mem_q[rd_ptr_q];
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/erpp_front.sv -----
module erpp_front import erpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic [7:0] device_id,
	output logic       pkt_push,
	output pkt_t       pkt
);

	phase_t      state_q, state_d;
	logic [3:0]  off_q;
	logic [3:0]  off_inc;
	logic        r_sign_q, l_sign_q;
	logic [15:0] r_rounds_q, r_pos_q, l_rounds_q;
	logic [7:0]  l_pos_hi_q;
	logic        is_sync;

	assign is_sync = (rx_byte == SYNC_BYTE);
	assign off_inc = off_q + 1'b1;

	always_comb begin
		state_d = state_q;
		if (accept) begin
			unique case (state_q)
				ST_FF1: begin
					state_d = is_sync ? ST_FF2 : ST_HUNT;
				end
				ST_FF2: begin
					if (rx_byte == device_id) begin
						state_d = ST_ID;
					end else if (is_sync) begin
						state_d = ST_FF2;
					end else begin
						state_d = ST_HUNT;
					end
				end
				ST_ID: begin
					if (rx_byte == LEN_MARK) begin
						state_d = ST_BODY;
					end else if (is_sync) begin
						// an id of FF leaves FF FF already matched
						state_d = (device_id == SYNC_BYTE) ? ST_FF2 : ST_FF1;
					end else begin
						state_d = ST_HUNT;
					end
				end
				ST_BODY: begin
					state_d = (off_inc >= LAST_OFF) ? ST_HUNT : ST_BODY;
				end
				default: begin
					state_d = is_sync ? ST_FF1 : ST_HUNT;
				end
			endcase
		end
	end

	always_comb begin
		pkt_push                = accept && (state_q == ST_BODY) && (off_inc >= LAST_OFF);
		pkt.left.pos_sign       = l_sign_q;
		pkt.left.rounds         = l_rounds_q;
		pkt.left.position       = {l_pos_hi_q, rx_byte};
		pkt.right.pos_sign      = r_sign_q;
		pkt.right.rounds        = r_rounds_q;
		pkt.right.position      = r_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			off_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (state_q == ST_ID && rx_byte == LEN_MARK) begin
					off_q <= BODY_OFF;
				end else if (state_q == ST_BODY) begin
					off_q <= pkt_push ? '0 : off_inc;
				end
			end
		end
	end

	// body capture, offsets counted from the first FF
	always_ff @(posedge clk) begin
		if (accept && state_q == ST_BODY) begin
			case (off_inc)
				4'd5:  r_sign_q          <= (rx_byte == 8'd1);
				4'd6:  r_rounds_q[15:8]  <= rx_byte;
				4'd7:  r_rounds_q[7:0]   <= rx_byte;
				4'd8:  r_pos_q[15:8]     <= rx_byte;
				4'd9:  r_pos_q[7:0]      <= rx_byte;
				4'd10: l_sign_q          <= (rx_byte == 8'd1);
				4'd11: l_rounds_q[15:8]  <= rx_byte;
				4'd12: l_rounds_q[7:0]   <= rx_byte;
				4'd13: l_pos_hi_q        <= rx_byte;
				default: ;
			endcase
		end
	end

	a_push_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_push |-> state_q == ST_BODY && off_q == LAST_OFF - 4'd1)
		else $error("packet pushed outside body end");

	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BODY |-> off_q >= BODY_OFF && off_q < LAST_OFF)
		else $error("body offset out of range");

endmodule

// ----- src/erpp_back.sv -----
module erpp_back import erpp_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] counts_per_round,
	input  pkt_t        pkt,
	input  q_stat_t     mid_stat,
	output logic        pkt_pop,
	input  logic        pop,
	output logic        empty,
	output ticks_t      ticks
);

	localparam int CW = $clog2(OUT_DEPTH+1);

	logic                      s1_valid_q, s2_valid_q;
	logic [31:0]               l_prod_s1, r_prod_s1;
	logic [15:0]               l_pos_s1, r_pos_s1;
	logic                      l_sign_s1, r_sign_s1;
	ticks_t                    ticks_s2;
	logic [CW-1:0]             out_cnt;
	logic [CW:0]               used;
	q_stat_t                   out_stat;
	logic [32:0]               l_mag, r_mag;
	ticks_t                    ticks_d;

	// room for everything in flight plus the request about to be taken
	assign used    = {1'b0, out_cnt} + (CW+1)'(s1_valid_q) + (CW+1)'(s2_valid_q);
	assign pkt_pop = !mid_stat.empty && (used < (CW+1)'(OUT_DEPTH));

	assign l_mag         = {17'd0, l_pos_s1} + {1'b0, l_prod_s1};
	assign r_mag         = {17'd0, r_pos_s1} + {1'b0, r_prod_s1};
	assign ticks_d.left  = l_sign_s1 ? $signed(l_mag) : -$signed(l_mag);
	assign ticks_d.right = r_sign_s1 ? $signed(r_mag) : -$signed(r_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= pkt_pop;
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_pop) begin
			l_prod_s1 <= pkt.left.rounds * counts_per_round;
			r_prod_s1 <= pkt.right.rounds * counts_per_round;
			l_pos_s1  <= pkt.left.position;
			r_pos_s1  <= pkt.right.position;
			l_sign_s1 <= pkt.left.pos_sign;
			r_sign_s1 <= pkt.right.pos_sign;
		end
		if (s1_valid_q) begin
			ticks_s2 <= ticks_d;
		end
	end

	erpp_fifo #(
		.WIDTH ($bits(ticks_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s2_valid_q),
		.din    (ticks_s2),
		.pop    (pop),
		.dout   (ticks),
		.stat   (out_stat),
		.count  (out_cnt)
	);

	assign empty = out_stat.empty;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> !out_stat.full)
		else $error("result queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_pop |-> !mid_stat.empty)
		else $error("request taken from empty queue");

endmodule
